>>> hdl/svm_pkg.sv
// Package for the stack VM call/return unit: opcode, status codes and payload structs.
// No dependencies.
package svm_pkg;

    localparam logic [1:0] OP_CALL  = 2'd0;
    localparam logic [1:0] OP_RET   = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_DEPTH    = 3'd2;
    localparam logic [2:0] ST_TERM     = 3'd3;
    localparam logic [2:0] ST_XMOD     = 3'd4;

    localparam logic CFG_STACK_LIMIT = 1'b0;
    localparam logic CFG_MAX_DEPTH   = 1'b1;

    localparam int META_SLOTS = 3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] target_pc;
        logic [63:0] next_pc;
        logic [11:0] param_cnt;
        logic [11:0] local_cnt;
        logic [11:0] frame_words;
        logic [11:0] arity;
        logic [11:0] base_offset;
        logic [11:0] height;
        logic [63:0] tos_word0;
        logic [63:0] tos_word1;
        logic [63:0] tos_word2;
    } svm_in_t;

    typedef struct packed {
        logic [63:0] continue_pc;
        logic [2:0]  status;
        logic [63:0] fill_word0;
        logic [63:0] fill_word1;
        logic [63:0] fill_word2;
        logic [11:0] frame_index;
    } svm_out_t;

endpackage

>>> hdl/stack_vm_call_return_unit_top.sv
// Top level of the stack VM call/return unit: sequencer around one stack memory.
// Depends on svm_pkg.
//
// channel | signals                      | direction
// in      | in_valid, in_ready, in_data  | transaction into the unit
// out     | out_valid, out_ready, out_data | one result transaction per input
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Call: spill three top-of-stack words, trap on stack limit or depth, else zero locals
// and write three metadata words. Return: read metadata, copy arity results, then
// terminate or read three fill words. Write, read: one word. One item at a time; one
// memory access per cycle sets the rate. Reset clears frame pointer and depth, sets
// stack limit 4096, max depth 1024; memory not cleared. A held result blocks the next item.
module stack_vm_call_return_unit_top #(
    parameter int STACK_WORDS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  svm_pkg::svm_in_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output svm_pkg::svm_out_t    out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import svm_pkg::*;

    localparam int AW = $clog2(STACK_WORDS);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SPILL = 11'b00000000010,
        S_ZERO  = 11'b00000000100,
        S_META  = 11'b00000001000,
        S_RMETA = 11'b00000010000,
        S_CRD   = 11'b00000100000,
        S_CWR   = 11'b00001000000,
        S_FILL  = 11'b00010000000,
        S_RDW   = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] mem [STACK_WORDS];
    logic [63:0] rdata_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    svm_in_t     item_reg;
    svm_out_t    res_reg;
    logic [AW-1:0] fp_reg;
    logic [15:0] depth_reg;
    logic [12:0] limit_reg;
    logic [15:0] maxd_reg;
    logic [12:0] cnt_reg;
    logic [1:0]  sub_reg;
    logic [63:0] rpc_reg, saved_reg;
    logic [AW-1:0] callee_reg, src_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    logic [AW-1:0] fp_in, wacc_addr, callee_in, src_in;
    logic [16:0] top_w;
    always_comb
    begin
        fp_in     = fp_reg;
        wacc_addr = AW'(fp_reg + AW'(in_data.base_offset) + AW'(in_data.height));
        callee_in = AW'(wacc_addr - AW'(in_data.param_cnt));
        src_in    = AW'(wacc_addr - AW'(in_data.arity));
        top_w = 17'(fp_reg) + 17'(item_reg.base_offset) + 17'(item_reg.height)
              + 17'(item_reg.local_cnt) + 17'(META_SLOTS);
    end

    logic [AW-1:0] frame_sz;
    assign frame_sz = AW'(fp_reg + AW'(item_reg.frame_words));

    always_comb
    begin
        state_next = state_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.opcode)
                        OP_CALL:  state_next = S_SPILL;
                        OP_RET:   state_next = S_RMETA;
                        OP_WRITE:
                        begin
                            we = 1'b1;
                            waddr = wacc_addr;
                            wdata = in_data.tos_word0;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            raddr = wacc_addr;
                            state_next = S_RDW;
                        end
                    endcase
                end
            end
            S_SPILL:
            begin
                we = 1'b1;
                waddr = AW'(fp_reg + AW'(sub_reg));
                wdata = (sub_reg == 2'd0) ? item_reg.tos_word0 :
                        (sub_reg == 2'd1) ? item_reg.tos_word1 : item_reg.tos_word2;
                if (sub_reg == 2'd2)
                begin
                    state_next = ((top_w > 17'(limit_reg))
                                  || depth_reg >= maxd_reg) ? S_OUT : S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (cnt_reg == 13'(item_reg.local_cnt))
                begin
                    state_next = S_META;
                end
                else
                begin
                    we = 1'b1;
                    waddr = AW'(callee_reg + AW'(item_reg.param_cnt) + AW'(cnt_reg));
                end
            end
            S_META:
            begin
                we = 1'b1;
                waddr = AW'(callee_reg + AW'(item_reg.param_cnt)
                        + AW'(item_reg.local_cnt) + AW'(sub_reg));
                wdata = (sub_reg == 2'd0) ? item_reg.next_pc :
                        (sub_reg == 2'd1) ? 64'(fp_reg) + 64'd1 : 64'd0;
                if (sub_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
            end
            S_RMETA:
            begin
                raddr = AW'(frame_sz + AW'(sub_reg));
                if (sub_reg == 2'd3)
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                if (cnt_reg == 13'(item_reg.arity))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = AW'(src_reg + AW'(cnt_reg));
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                we = 1'b1;
                waddr = AW'(fp_reg + AW'(cnt_reg));
                wdata = rdata_reg;
                state_next = S_CRD;
            end
            S_DONE:
            begin
                state_next = (saved_reg == 64'd0) ? S_OUT : S_FILL;
            end
            S_FILL:
            begin
                raddr = AW'(fp_reg + AW'(sub_reg));
                if (sub_reg == 2'd3)
                begin
                    state_next = S_OUT;
                end
            end
            S_RDW:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fp_reg    <= '0;
            depth_reg <= '0;
            limit_reg <= 13'd4096;
            maxd_reg  <= 16'd1024;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_STACK_LIMIT)
                begin
                    limit_reg <= cfg_data[12:0];
                end
                else
                begin
                    maxd_reg <= cfg_data;
                end
            end
            if (state_reg == S_META && sub_reg == 2'd2)
            begin
                depth_reg <= depth_reg + 16'd1;
                fp_reg    <= callee_reg;
            end
            if (state_reg == S_DONE)
            begin
                if (depth_reg != 16'd0)
                begin
                    depth_reg <= depth_reg - 16'd1;
                end
                if (saved_reg != 64'd0)
                begin
                    fp_reg <= AW'(saved_reg - 64'd1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg   <= in_data;
                callee_reg <= callee_in;
                src_reg    <= src_in;
                cnt_reg    <= '0;
                sub_reg    <= '0;
                res_reg    <= '{continue_pc: 64'd0, status: ST_OK, fill_word0: 64'd0,
                                fill_word1: 64'd0, fill_word2: 64'd0,
                                frame_index: 12'(fp_in)};
            end
            S_SPILL:
            begin
                sub_reg <= (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                if (sub_reg == 2'd2)
                begin
                    if (top_w > 17'(limit_reg))
                    begin
                        res_reg.status <= ST_OVERFLOW;
                    end
                    else if (depth_reg >= maxd_reg)
                    begin
                        res_reg.status <= ST_DEPTH;
                    end
                end
            end
            S_ZERO:  cnt_reg <= cnt_reg + 13'd1;
            S_META:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd2)
                begin
                    res_reg.continue_pc <= item_reg.target_pc;
                    res_reg.frame_index <= 12'(callee_reg);
                end
            end
            S_RMETA:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd1) rpc_reg <= rdata_reg;
                if (sub_reg == 2'd2) saved_reg <= rdata_reg;
                if (sub_reg == 2'd3)
                begin
                    res_reg.status <= (rdata_reg != 64'd0) ? ST_XMOD : ST_OK;
                end
            end
            S_CWR:   cnt_reg <= cnt_reg + 13'd1;
            S_DONE:
            begin
                sub_reg <= '0;
                if (saved_reg == 64'd0)
                begin
                    res_reg.status <= ST_TERM;
                end
                else
                begin
                    res_reg.continue_pc <= rpc_reg;
                    res_reg.frame_index <= 12'(AW'(saved_reg - 64'd1));
                end
            end
            S_FILL:
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd1) res_reg.fill_word0 <= rdata_reg;
                if (sub_reg == 2'd2) res_reg.fill_word1 <= rdata_reg;
                if (sub_reg == 2'd3) res_reg.fill_word2 <= rdata_reg;
            end
            S_RDW:   res_reg.fill_word0 <= rdata_reg;
            default: ;
        endcase
    end

endmodule

>>> hdl/svm_checker.sv
// Port-level checker for the stack VM call/return unit, bound to the top level.
// Depends on svm_pkg.
module svm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input svm_pkg::svm_out_t out_data
);
    import svm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_XMOD)
        else $error("bad status");

    a_trap_pc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OVERFLOW || out_data.status == ST_DEPTH
                      || out_data.status == ST_TERM) |-> out_data.continue_pc == 64'd0)
        else $error("trap with nonzero pc");

endmodule

bind stack_vm_call_return_unit_top svm_checker u_svm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
